// ===== sv/hcbd_pkg.sv =====
// Shared types and constants for the chunked HTTP body decoder.
// No dependencies; every other file imports this package.
package hcbd_pkg;

    // Width of the chunk size accumulator and the payload byte counter.
    localparam int SIZE_BITS = 32;

    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_SP  = 8'h20;
    localparam logic [7:0] CHAR_TAB = 8'h09;

    // Bytes skipped after each chunk's payload.
    localparam logic [1:0] TRAILER_LEN = 2'd2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       frame_start;
    } byte_item_t;

    typedef struct packed {
        logic [7:0] body_byte;
        logic       is_data;
        logic       end_of_body;
        logic       parse_error;
    } result_t;

    // A byte after classification by the front end.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
        logic       is_hex;
        logic [3:0] hex_val;
        logic       is_cr;
        logic       is_lf;
        logic       is_blank;
    } class_item_t;

    typedef enum logic [1:0] {
        PH_SIZE,
        PH_DATA,
        PH_TRAILER,
        PH_DONE
    } phase_t;

endpackage

// ===== sv/hcbd_front.sv =====
// Front end of the chunked body decoder: accepts raw bytes and classifies them.
// Depends on hcbd_pkg.
module hcbd_front (
    input  logic                item_valid,
    output logic                item_ready,
    input  hcbd_pkg::byte_item_t item,
    input  logic                queue_full,
    output logic                push,
    output hcbd_pkg::class_item_t cls
);
    import hcbd_pkg::*;

    logic [7:0] c;

    assign c          = item.in_byte;
    assign item_ready = !queue_full;
    assign push       = item_valid && !queue_full;

    always_comb
    begin
        cls             = '0;
        cls.data_byte   = c;
        cls.frame_start = item.frame_start;
        cls.is_cr       = (c == CHAR_CR);
        cls.is_lf       = (c == CHAR_LF);
        cls.is_blank    = (c == CHAR_SP) || (c == CHAR_TAB);
        if (c >= 8'h30 && c <= 8'h39)
        begin
            cls.is_hex  = 1'b1;
            cls.hex_val = c[3:0];
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
        begin
            // Letters a to f and A to F share their low three bits.
            cls.is_hex  = 1'b1;
            cls.hex_val = 4'(c[2:0] + 3'd1) + 4'd8;
        end
    end

endmodule

// ===== sv/hcbd_queue.sv =====
// Two-entry queue of classified bytes between front and back end.
// Depends on hcbd_pkg.
module hcbd_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  hcbd_pkg::class_item_t push_item,
    output logic                  full,
    input  logic                  pop,
    output logic                  not_empty,
    output hcbd_pkg::class_item_t head
);
    import hcbd_pkg::*;

    class_item_t slot_reg [2];
    logic        rd_ptr_reg, rd_ptr_next;
    logic        wr_ptr_reg, wr_ptr_next;
    logic [1:0]  count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== sv/hcbd_back.sv =====
// Back end of the chunked body decoder: chunk state machine and result register.
// Depends on hcbd_pkg.
module hcbd_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  not_empty,
    input  hcbd_pkg::class_item_t head,
    output logic                  pop,
    output logic                  result_valid,
    input  logic                  result_ready,
    output hcbd_pkg::result_t     result
);
    import hcbd_pkg::*;

    phase_t                 phase_reg, phase_next;
    logic [SIZE_BITS-1:0]   rem_reg, rem_next;
    logic [SIZE_BITS-1:0]   acc_reg, acc_next;
    logic                   seen_reg, seen_next;
    logic                   closed_reg, closed_next;
    logic                   cr_reg, cr_next;
    logic [1:0]             tl_reg, tl_next;
    logic                   out_valid_reg, out_valid_next;
    result_t                out_reg, out_next;

    phase_t                 ph;
    logic [SIZE_BITS-1:0]   rem;
    logic [SIZE_BITS-1:0]   acc;
    logic                   seen;
    logic                   closed;
    logic                   cr;
    logic [1:0]             tl;
    logic                   res_v;
    result_t                res;

    assign pop          = not_empty && (!out_valid_reg || result_ready);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_comb
    begin
        // A frame start puts the parser back to its reset state first.
        ph     = head.frame_start ? PH_SIZE : phase_reg;
        rem    = head.frame_start ? '0 : rem_reg;
        acc    = head.frame_start ? '0 : acc_reg;
        seen   = head.frame_start ? 1'b0 : seen_reg;
        closed = head.frame_start ? 1'b0 : closed_reg;
        cr     = head.frame_start ? 1'b0 : cr_reg;
        tl     = head.frame_start ? 2'd0 : tl_reg;

        phase_next  = ph;
        rem_next    = rem;
        acc_next    = acc;
        seen_next   = seen;
        closed_next = closed;
        cr_next     = cr;
        tl_next     = tl;
        res_v       = 1'b0;
        res         = '0;

        unique case (ph)
            PH_DATA:
            begin
                if (rem != '0)
                begin
                    rem_next = rem - SIZE_BITS'(1);
                end
                if (rem[SIZE_BITS-1:1] == '0)
                begin
                    phase_next = PH_TRAILER;
                    tl_next    = TRAILER_LEN;
                end
                res_v         = 1'b1;
                res.body_byte = head.data_byte;
                res.is_data   = 1'b1;
            end
            PH_TRAILER:
            begin
                if (tl != 2'd0)
                begin
                    tl_next = tl - 2'd1;
                end
                if (tl[1] == 1'b0)
                begin
                    phase_next  = PH_SIZE;
                    acc_next    = '0;
                    seen_next   = 1'b0;
                    closed_next = 1'b0;
                    cr_next     = 1'b0;
                end
            end
            PH_SIZE:
            begin
                if (cr && head.is_lf)
                begin
                    if (!seen)
                    begin
                        phase_next      = PH_DONE;
                        res_v           = 1'b1;
                        res.parse_error = 1'b1;
                    end
                    else if (acc == '0)
                    begin
                        phase_next      = PH_DONE;
                        res_v           = 1'b1;
                        res.end_of_body = 1'b1;
                    end
                    else
                    begin
                        rem_next    = acc;
                        phase_next  = PH_DATA;
                        acc_next    = '0;
                        seen_next   = 1'b0;
                        closed_next = 1'b0;
                        cr_next     = 1'b0;
                    end
                end
                else
                begin
                    cr_next = head.is_cr;
                    if (!closed)
                    begin
                        if (head.is_hex)
                        begin
                            if (acc[SIZE_BITS-1 -: 4] != 4'd0)
                            begin
                                phase_next      = PH_DONE;
                                res_v           = 1'b1;
                                res.parse_error = 1'b1;
                            end
                            else
                            begin
                                acc_next  = {acc[SIZE_BITS-5:0], head.hex_val};
                                seen_next = 1'b1;
                            end
                        end
                        else if (seen || !head.is_blank)
                        begin
                            closed_next = 1'b1;
                        end
                    end
                end
            end
            PH_DONE:
            begin
                // Bytes are dropped until the next frame start.
            end
            default:
            begin
            end
        endcase

        out_valid_next = out_valid_reg && !result_ready;
        out_next       = out_reg;
        if (pop && res_v)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SIZE;
        end
        else if (pop)
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg       <= '0;
            acc_reg       <= '0;
            seen_reg      <= 1'b0;
            closed_reg    <= 1'b0;
            cr_reg        <= 1'b0;
            tl_reg        <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                rem_reg    <= rem_next;
                acc_reg    <= acc_next;
                seen_reg   <= seen_next;
                closed_reg <= closed_next;
                cr_reg     <= cr_next;
                tl_reg     <= tl_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

// ===== sv/http_chunked_body_decoder_top.sv =====
// Chunked HTTP body decoder: one byte in, at most one result item out.
// Throughput is one byte per cycle while results are taken; a result passes through
// the classify queue and then the result register of the back end after its byte is accepted.
// Reset (rst_n low, asynchronous) empties the queue and result register and puts
// the parser in the size line phase with all counters cleared.
// Depends on hcbd_pkg, hcbd_front, hcbd_queue and hcbd_back.
module http_chunked_body_decoder_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    output logic                 byte_ready,
    input  hcbd_pkg::byte_item_t byte_item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output hcbd_pkg::result_t    result
);
    import hcbd_pkg::*;

    // The front end decodes each byte into flags (hex digit and its value,
    // CR, LF, blank) so the back end only has to step the chunk state machine.
    class_item_t cls;
    class_item_t head;
    logic        push;
    logic        full;
    logic        pop;
    logic        not_empty;

    hcbd_front u_front (
        .item_valid (byte_valid),
        .item_ready (byte_ready),
        .item       (byte_item),
        .queue_full (full),
        .push       (push),
        .cls        (cls)
    );

    // The queue lets the input keep flowing until it is full while the result
    // register is stalled, and the back end drain while no bytes arrive.
    hcbd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (cls),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .head      (head)
    );

    // The back end pops one item per cycle whenever the queue holds one and its
    // result register is free or is being emptied in the same cycle.
    hcbd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .not_empty    (not_empty),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
